// ----- hw/rtl/output_protection_shutdown_controller_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the output protection shutdown controller
// Shared property wrappers, clocked on i_clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_PROTECTION_SHUTDOWN_CONTROLLER_UNIT_DEFINES_SVH
`define OUTPUT_PROTECTION_SHUTDOWN_CONTROLLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OPSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/opsc_pkg.sv -----
// ----------------------------------------------------------------------------
// opsc_pkg
// Types, codes and constants of the output protection shutdown controller.
// ----------------------------------------------------------------------------
`default_nettype none

package opsc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SHUTDOWN_MODE = 2'd0,
        CFG_OC_DELAY      = 2'd1,
        CFG_TIME_LIMIT    = 2'd2,
        CFG_SETPOINT      = 2'd3
    } t_cfg_reg;

    // Disable causes, in priority order.
    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_SENSOR_ERR  = 3'd1,
        CAUSE_OVERHEAT    = 3'd2,
        CAUSE_LOW_INPUT   = 3'd3,
        CAUSE_OVERCURRENT = 3'd4,
        CAUSE_TIMEOUT     = 3'd5,
        CAUSE_LOW_CURRENT = 3'd6,
        CAUSE_REQUEST     = 3'd7
    } t_cause;

    // Shutdown mode codes; the other codes behave as no special shutdown.
    localparam logic [1:0] MODE_OVERCURRENT = 2'd1;
    localparam logic [1:0] MODE_LOW_CURRENT = 2'd2;

    // Temperature state codes; the remaining codes mean not yet valid.
    localparam logic [1:0] TEMP_OK         = 2'd0;
    localparam logic [1:0] TEMP_SENSOR_ERR = 2'd1;

    localparam int NUM_RAILS = 5;

    localparam logic [5:0]         LIMIT_FILTER_MAX = 6'd40;
    localparam logic [10:0]        LOW_CURRENT_MS   = 11'd1000;
    localparam logic [10:0]        LOW_CURRENT_SAT  = 11'd2047;
    localparam logic signed [11:0] OVERHEAT_DECIDEG = 12'sd800;
    localparam logic [16:0]        RAIL_STEP_MV     = 17'd9500;

    // Divide-by-ten of the 23-bit setpoint: floor(2^23 / 10) reciprocal.
    localparam int          RECIP_SHIFT = 23;
    localparam logic [19:0] RECIP_TEN   = 20'd838860;
    localparam logic [22:0] DIV_TEN     = 23'd10;

    typedef struct packed {
        logic [1:0]  shutdown_mode;
        logic [31:0] oc_delay_ms;
        logic [31:0] time_limit_ms;
        logic [19:0] low_thresh_ua;
    } t_cfg;

    typedef struct packed {
        logic                       enable_request;
        logic                       cc_mode;
        logic                       overcurrent_event;
        logic signed [23:0]         measured_current_ua;
        logic [1:0]                 temp_state;
        logic signed [11:0]         heatsink_decideg;
        logic [NUM_RAILS-1:0][16:0] supply_mv;
    } t_item;

    typedef struct packed {
        logic        output_on;
        t_cause      last_disable_cause;
        logic [5:0]  error_bits;
        logic        overheated;
        logic        limiting;
        logic [31:0] on_time_ms;
        logic        overcurrent_armed;
        logic        clear_request;
    } t_result;

    // Minimum good voltage of rail k (0-based): 9.5 V times k+1.
    function automatic logic [16:0] rail_min_mv(input int k);
        rail_min_mv = 17'(RAIL_STEP_MV * (k + 1));
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/output_protection_shutdown_controller_unit.sv -----
// Path: a tick is held in the input register, then its result in the result
// register; a full result register stalls the input register.
// Throughput: one tick per cycle while the result stream is not stalled; the core
// updates its state as a tick advances, and the result register frees the input side while a result waits.
// Reset: synchronous, active low; clears all protection state, the valid
// flags and the configuration registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
// output_protection_shutdown_controller_unit
// Top level: stream handshake, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module output_protection_shutdown_controller_unit
    import opsc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration write channel.
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    // Tick input stream.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata from bit 0: enable_request, cc_mode, overcurrent_event,
    // measured_current_ua[23:0], temp_state[1:0], heatsink_decideg[11:0],
    // supply1_mv, supply2_mv, supply3_mv, supply4_mv, supply_g_mv (17 each),
    // two zero bits.
    input  wire logic [127:0] i_s_axis_tdata,
    // Result stream.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata from bit 0: output_on, last_disable_cause[2:0], error_bits[5:0],
    // overheated, limiting, on_time_ms[31:0], overcurrent_armed,
    // clear_request, two zero bits.
    output logic [47:0]       o_m_axis_tdata
);

    logic [1:0]  r_shutdown_mode;
    logic [31:0] r_oc_delay;
    logic [31:0] r_time_limit;
    logic [22:0] r_setpoint;
    logic [19:0] r_thresh;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;

    t_item       w_item;
    t_cfg        w_cfg;
    t_result     w_result;
    logic        w_adv;
    logic        w_out_free;
    logic [42:0] w_prod;
    logic [19:0] w_q0;
    logic [22:0] w_rem;

    // Configuration registers; always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shutdown_mode <= '0;
            r_oc_delay      <= '0;
            r_time_limit    <= '0;
            r_setpoint      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SHUTDOWN_MODE: r_shutdown_mode <= i_cfg_data[1:0];
                CFG_OC_DELAY:      r_oc_delay      <= i_cfg_data;
                CFG_TIME_LIMIT:    r_time_limit    <= i_cfg_data;
                CFG_SETPOINT:      r_setpoint      <= i_cfg_data[22:0];
            endcase
        end
    end

    // Low-current threshold: setpoint divided by ten through a reciprocal
    // multiply that may fall one short, then a single correction step.
    always_comb begin
        w_prod = 43'(r_setpoint) * 43'(RECIP_TEN);
        w_q0   = w_prod[RECIP_SHIFT +: 20];
        w_rem  = r_setpoint - 23'(23'(w_q0) * DIV_TEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else begin
            r_thresh <= (w_rem >= DIV_TEN) ? w_q0 + 20'd1 : w_q0;
        end
    end

    assign w_cfg = '{shutdown_mode: r_shutdown_mode, oc_delay_ms: r_oc_delay,
                     time_limit_ms: r_time_limit, low_thresh_ua: r_thresh};

    // Unpack the incoming tick.
    always_comb begin
        w_item.enable_request      = i_s_axis_tdata[0];
        w_item.cc_mode             = i_s_axis_tdata[1];
        w_item.overcurrent_event   = i_s_axis_tdata[2];
        w_item.measured_current_ua = $signed(i_s_axis_tdata[26:3]);
        w_item.temp_state          = i_s_axis_tdata[28:27];
        w_item.heatsink_decideg    = $signed(i_s_axis_tdata[40:29]);
        for (int k = 0; k < NUM_RAILS; k++) begin
            w_item.supply_mv[k] = i_s_axis_tdata[41 + 17*k +: 17];
        end
    end

    // Two-stage handshake: a tick advances when the result register is free.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= w_item;
        end
    end

    opsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.clear_request, r_out.overcurrent_armed,
                              r_out.on_time_ms, r_out.limiting, r_out.overheated,
                              r_out.error_bits, r_out.last_disable_cause, r_out.output_on};

    `include "output_protection_shutdown_controller_unit_defines.svh"

    `OPSC_ASSERT_SAME(a_clr_turns_off, r_out_valid && r_out.clear_request, !r_out.output_on, "clear request with output still on")
    `OPSC_ASSERT_SAME(a_clr_has_cause, r_out_valid && r_out.clear_request, r_out.last_disable_cause != CAUSE_NONE, "clear request without a latched cause")
    `OPSC_ASSERT_SAME(a_armed_needs_on, r_out_valid && r_out.overcurrent_armed, r_out.output_on, "overcurrent armed while output off")
    `OPSC_ASSERT_SAME(a_stall_is_full, !o_s_axis_tready, r_in_valid && r_out_valid, "input stalled without both stages full")
    `OPSC_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid, "advanced tick did not reach the result register")

endmodule

`default_nettype wire

// ----- hw/rtl/opsc_core.sv -----
// ----------------------------------------------------------------------------
// opsc_core
// Protection state and the one-tick update that turns a tick into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module opsc_core
    import opsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_adv,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic        r_enabled,  n_enabled;
    logic [31:0] r_elapsed,  n_elapsed;
    logic [10:0] r_lc_ticks, n_lc_ticks;
    logic [5:0]  r_lfilt,    n_lfilt;
    logic        r_armed,    n_armed;
    logic        r_pending,  n_pending;
    t_cause      r_latch,    n_latch;

    logic        w_hot;
    logic        w_limited;
    logic        w_lowc;
    logic        w_clr;
    logic        w_oc_time;
    logic [5:0]  w_err;
    logic [31:0] w_el1;
    logic        w_pend1;
    t_cause      w_cause;

    // Rail undervoltage and temperature flags.
    always_comb begin
        w_err = '0;
        for (int k = 0; k < NUM_RAILS; k++) begin
            w_err[k] = i_item.supply_mv[k] < rail_min_mv(k);
        end
        w_err[5] = (i_item.temp_state == TEMP_SENSOR_ERR);
        w_hot    = (i_item.temp_state == TEMP_OK) &&
                   (i_item.heatsink_decideg > OVERHEAT_DECIDEG);
    end

    // Counters and filters that do not depend on the chosen cause.
    always_comb begin
        w_pend1   = r_pending | (r_armed & i_item.overcurrent_event);
        w_el1     = r_enabled ? r_elapsed + 32'd1 : r_elapsed;
        w_oc_time = (w_el1 >= i_cfg.oc_delay_ms);
        w_limited = 1'b0;
        n_lfilt   = '0;
        if (i_item.cc_mode) begin
            if (r_lfilt < LIMIT_FILTER_MAX) begin
                n_lfilt = r_lfilt + 6'd1;
            end else begin
                n_lfilt   = r_lfilt;
                w_limited = 1'b1;
            end
        end
        w_lowc = r_enabled &&
                 (i_item.measured_current_ua < $signed({4'b0, i_cfg.low_thresh_ua}));
        if (w_lowc) begin
            n_lc_ticks = (r_lc_ticks < LOW_CURRENT_SAT) ? r_lc_ticks + 11'd1 : r_lc_ticks;
        end else begin
            n_lc_ticks = '0;
        end
    end

    // Cause selection by priority, then arming, enabling and disabling.
    always_comb begin
        n_pending = w_pend1;
        n_armed   = r_armed;
        n_enabled = r_enabled;
        n_elapsed = w_el1;
        n_latch   = r_latch;
        w_clr     = 1'b0;
        priority if (w_err[5]) begin
            w_cause = CAUSE_SENSOR_ERR;
        end else if (w_hot) begin
            w_cause = CAUSE_OVERHEAT;
        end else if (|w_err[4:0]) begin
            w_cause = CAUSE_LOW_INPUT;
        end else if (r_enabled && i_cfg.shutdown_mode == MODE_OVERCURRENT && w_oc_time &&
                     (w_pend1 || i_item.cc_mode)) begin
            w_cause   = CAUSE_OVERCURRENT;
            n_pending = 1'b0;
        end else if (r_enabled && (i_cfg.time_limit_ms != '0) &&
                     (w_el1 >= i_cfg.time_limit_ms)) begin
            w_cause = CAUSE_TIMEOUT;
        end else if (i_cfg.shutdown_mode == MODE_LOW_CURRENT &&
                     n_lc_ticks > LOW_CURRENT_MS) begin
            w_cause = CAUSE_LOW_CURRENT;
        end else if (r_enabled && !i_item.enable_request) begin
            w_cause = CAUSE_REQUEST;
        end else begin
            w_cause = CAUSE_NONE;
        end

        if (i_cfg.shutdown_mode == MODE_OVERCURRENT && r_enabled && w_oc_time) begin
            n_armed = 1'b1;
        end

        if (!r_enabled && i_item.enable_request) begin
            n_enabled = 1'b1;
            n_elapsed = '0;
            n_latch   = CAUSE_NONE;
        end

        if (n_enabled && w_cause != CAUSE_NONE) begin
            n_armed   = 1'b0;
            n_enabled = 1'b0;
            n_latch   = w_cause;
            w_clr     = 1'b1;
        end
    end

    // Result of this tick.
    always_comb begin
        o_result.output_on          = n_enabled;
        o_result.last_disable_cause = n_latch;
        o_result.error_bits         = w_err;
        o_result.overheated         = w_hot;
        o_result.limiting           = i_item.enable_request & w_limited;
        o_result.on_time_ms         = n_elapsed;
        o_result.overcurrent_armed  = n_armed;
        o_result.clear_request      = w_clr;
    end

    // State advances only when the tick moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_elapsed  <= '0;
            r_lc_ticks <= '0;
            r_lfilt    <= '0;
            r_armed    <= 1'b0;
            r_pending  <= 1'b0;
            r_latch    <= CAUSE_NONE;
        end else if (i_adv) begin
            r_enabled  <= n_enabled;
            r_elapsed  <= n_elapsed;
            r_lc_ticks <= n_lc_ticks;
            r_lfilt    <= n_lfilt;
            r_armed    <= n_armed;
            r_pending  <= n_pending;
            r_latch    <= n_latch;
        end
    end

endmodule

`default_nettype wire
